[src/trms_pkg.sv]
// ============================================================================
// trms_pkg: shared types and constants for the three-channel RMS meter
// Payload structs, datapath command/status groups and register indexes.
// ============================================================================
package trms_pkg;

    localparam int MAX_COUNT = 1024;
    localparam int SUM_BITS  = 48;
    localparam int CNT_BITS  = $clog2(MAX_COUNT + 1);
    localparam int NUM_CH    = 3;

    localparam logic [2:0] REG_IV_GAIN = 3'd0;
    localparam logic [2:0] REG_GV_GAIN = 3'd1;
    localparam logic [2:0] REG_GC_GAIN = 3'd2;
    localparam logic [2:0] REG_IV_OFF  = 3'd3;
    localparam logic [2:0] REG_GV_OFF  = 3'd4;
    localparam logic [2:0] REG_GC_OFF  = 3'd5;

    localparam logic [15:0] GAIN_RESET = 16'd4096;
    localparam logic [16:0] RMS_CLAMP  = 17'd32768;

    typedef struct packed {
        logic        command;
        logic [11:0] inverter_voltage_raw;
        logic [11:0] grid_voltage_raw;
        logic [11:0] grid_current_raw;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] inverter_voltage_value;
        logic signed [15:0] grid_voltage_value;
        logic signed [15:0] grid_current_value;
        logic [15:0]        inverter_voltage_rms;
        logic [15:0]        grid_voltage_rms;
        logic [15:0]        grid_current_rms;
        logic               rms_valid;
        logic               empty_period;
    } out_item_t;

    typedef struct packed {
        logic load;      // capture input item
        logic scale;     // multiply stage
        logic accum;     // offset, saturate, square, accumulate, build sample result
        logic div_start; // begin division of channel sums
        logic div_step;  // one quotient bit
        logic sqrt_start;
        logic sqrt_step; // one root bit
        logic next_ch;   // store root, advance channel
        logic finish;    // build period result, clear sums
    } dp_cmd_t;

    typedef struct packed {
        logic command;
        logic empty;
        logic div_last;
        logic sqrt_last;
        logic ch_last;
    } dp_sts_t;

endpackage

[src/trms_ctrl.sv]
// ============================================================================
// trms_ctrl: sequencer for the RMS meter
// Steps the datapath through sample scaling or the per-channel divide/root.
// ============================================================================
module trms_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic              out_free,
    input  trms_pkg::dp_sts_t sts,
    output trms_pkg::dp_cmd_t cmd,
    output logic              busy,
    output logic              out_load
);
    import trms_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECODE = 9'b000000010,
        ST_SCALE  = 9'b000000100,
        ST_ACCUM  = 9'b000001000,
        ST_DIV    = 9'b000010000,
        ST_SQRT0  = 9'b000100000,
        ST_SQRT   = 9'b001000000,
        ST_FINISH = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = in_fire;
                if (in_fire) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (!sts.command) begin
                    cmd.scale  = 1'b1;
                    state_next = ST_SCALE;
                end else if (sts.empty) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_SCALE: begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_OUT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_SQRT0;
            end
            ST_SQRT0: begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last) begin
                    cmd.next_ch = 1'b1;
                    if (sts.ch_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_load_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == ST_IDLE) else $error("load outside idle");
    a_out_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> state_reg == ST_IDLE) else $error("out not followed by idle");
    a_accum_from_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accum |-> $past(state_reg) == ST_SCALE) else $error("accum order");
`endif

endmodule

[src/trms_dp.sv]
// ============================================================================
// trms_dp: datapath for the RMS meter
// Config registers, scaling, square sums, shared divider and root unit.
// ============================================================================
module trms_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  trms_pkg::in_item_t  in_item,
    input  trms_pkg::dp_cmd_t   cmd,
    output trms_pkg::dp_sts_t   sts,
    output trms_pkg::out_item_t result
);
    import trms_pkg::*;

    localparam int IDX_BITS  = $clog2(SUM_BITS);
    localparam int ROOT_BITS = SUM_BITS / 2;
    localparam int RIDX_BITS = $clog2(ROOT_BITS);
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    logic [15:0]        gain_reg [NUM_CH];
    logic signed [15:0] off_reg  [NUM_CH];
    in_item_t           item_reg;
    logic [27:0]        prod_reg [NUM_CH];
    logic [SUM_BITS-1:0] sum_reg [NUM_CH];
    logic [CNT_BITS-1:0] cnt_reg;
    out_item_t          result_reg;
    out_item_t          result_next;

    logic [1:0]          ch_reg;
    logic [SUM_BITS-1:0] dividend_reg;
    logic [CNT_BITS-1:0] rem_reg;
    logic [IDX_BITS-1:0] div_idx_reg;
    logic [SUM_BITS+1:0] rad_reg;
    logic [ROOT_BITS:0]  root_reg;
    logic [ROOT_BITS+2:0] srem_reg;
    logic [RIDX_BITS-1:0] sq_idx_reg;
    logic [15:0]         rms_reg [NUM_CH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CH; i++) begin
                gain_reg[i] <= GAIN_RESET;
                off_reg[i]  <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IV_GAIN: gain_reg[0] <= cfg_data;
                REG_GV_GAIN: gain_reg[1] <= cfg_data;
                REG_GC_GAIN: gain_reg[2] <= cfg_data;
                REG_IV_OFF:  off_reg[0]  <= cfg_data;
                REG_GV_OFF:  off_reg[1]  <= cfg_data;
                REG_GC_OFF:  off_reg[2]  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [11:0] raw [NUM_CH];
    assign raw[0] = item_reg.inverter_voltage_raw;
    assign raw[1] = item_reg.grid_voltage_raw;
    assign raw[2] = item_reg.grid_current_raw;

    // offset, saturate, square per channel
    logic signed [15:0]  val [NUM_CH];
    logic [SUM_BITS-1:0] sum_add [NUM_CH];
    always_comb begin
        logic signed [17:0] d;
        logic [31:0] sq;
        logic [SUM_BITS:0] s;
        for (int i = 0; i < NUM_CH; i++) begin
            d = $signed({2'b00, prod_reg[i][27:12]}) - 18'(off_reg[i]);
            if (d > 18'sd32767)       val[i] = 16'sh7FFF;
            else if (d < -18'sd32768) val[i] = 16'sh8000;
            else                      val[i] = d[15:0];
            sq = 32'(val[i] * val[i]);
            s  = {1'b0, sum_reg[i]} + (SUM_BITS+1)'(sq);
            sum_add[i] = s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
        end
    end

    // restoring divide, one quotient bit a cycle
    logic [CNT_BITS:0] rem_sh;
    assign rem_sh = {rem_reg, dividend_reg[SUM_BITS-1]};
    logic              rem_ge;
    assign rem_ge = rem_sh >= {1'b0, cnt_reg};

    // bitwise root, one bit a cycle
    logic [ROOT_BITS+2:0] s_sh, s_trial;
    assign s_sh    = {srem_reg[ROOT_BITS:0], rad_reg[SUM_BITS-1:SUM_BITS-2]};
    assign s_trial = {root_reg, 2'b01};
    logic [ROOT_BITS:0] root_fin;
    assign root_fin = (s_sh >= s_trial) ? {root_reg[ROOT_BITS-1:0], 1'b1}
                                        : {root_reg[ROOT_BITS-1:0], 1'b0};

    // sample result carries the scaled values, period result the roots or the empty flag
    always_comb begin
        result_next = '0;
        if (cmd.accum) begin
            result_next.inverter_voltage_value = val[0];
            result_next.grid_voltage_value     = val[1];
            result_next.grid_current_value     = val[2];
        end else if (cnt_reg == '0) begin
            result_next.empty_period = 1'b1;
        end else begin
            result_next.inverter_voltage_rms = rms_reg[0];
            result_next.grid_voltage_rms     = rms_reg[1];
            result_next.grid_current_rms     = rms_reg[2];
            result_next.rms_valid            = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CH; i++) sum_reg[i] <= '0;
            cnt_reg <= CNT_BITS'(1);
        end else if (cmd.accum) begin
            for (int i = 0; i < NUM_CH; i++) sum_reg[i] <= sum_add[i];
            if (cnt_reg < CNT_BITS'(MAX_COUNT)) cnt_reg <= cnt_reg + 1'b1;
        end else if (cmd.finish) begin
            for (int i = 0; i < NUM_CH; i++) sum_reg[i] <= '0;
            cnt_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= in_item;
        if (cmd.scale) begin
            for (int i = 0; i < NUM_CH; i++) prod_reg[i] <= gain_reg[i] * raw[i];
        end
        if (cmd.div_start) begin
            dividend_reg <= sum_reg[cmd.next_ch ? ch_reg + 2'd1 : 2'd0];
            rem_reg      <= '0;
            div_idx_reg  <= IDX_BITS'(SUM_BITS - 1);
            if (!cmd.next_ch) ch_reg <= 2'd0;
        end else if (cmd.div_step) begin
            rem_reg      <= rem_ge ? CNT_BITS'(rem_sh - {1'b0, cnt_reg})
                                   : rem_sh[CNT_BITS-1:0];
            dividend_reg <= {dividend_reg[SUM_BITS-2:0], rem_ge};
            div_idx_reg  <= div_idx_reg - 1'b1;
        end
        if (cmd.sqrt_start) begin
            rad_reg    <= {2'b00, dividend_reg};
            root_reg   <= '0;
            srem_reg   <= '0;
            sq_idx_reg <= RIDX_BITS'(ROOT_BITS - 1);
        end else if (cmd.sqrt_step) begin
            srem_reg   <= (s_sh >= s_trial) ? s_sh - s_trial : s_sh;
            root_reg   <= root_fin;
            rad_reg    <= {rad_reg[SUM_BITS-1:0], 2'b00};
            sq_idx_reg <= sq_idx_reg - 1'b1;
        end
        if (cmd.next_ch) begin
            rms_reg[ch_reg] <= ({1'b0, root_fin} > (ROOT_BITS+2)'(RMS_CLAMP))
                               ? 16'h8000 : root_fin[15:0];
            ch_reg <= ch_reg + 2'd1;
        end
        if (cmd.accum || cmd.finish) result_reg <= result_next;
    end

    assign sts.command   = item_reg.command;
    assign sts.empty     = (cnt_reg == '0);
    assign sts.div_last  = (div_idx_reg == '0);
    assign sts.sqrt_last = (sq_idx_reg == '0);
    assign sts.ch_last   = (ch_reg == 2'd2);
    assign result        = result_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_BITS'(MAX_COUNT)) else $error("count beyond max");
    a_clear_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> cnt_reg == '0 && sum_reg[0] == '0) else $error("no clear");
    a_div_before_sqrt: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sqrt_start |-> $past(cmd.div_step)) else $error("sqrt order");
`endif

endmodule

[src/three_channel_rms_meter_unit.sv]
// ============================================================================
// three_channel_rms_meter_unit: three-channel true-RMS meter
// Scales three converter samples, accumulates squares, reports RMS per period.
// ============================================================================
// Operation: a sample transfer (command 0) goes through the decode, scale,
// accumulate and output states; an end-of-period transfer (command 1) runs the
// shared bit-serial divider (one quotient bit a cycle) and root unit (one root
// bit a cycle) on the three channel sums in turn, then finish and output; with
// a zero count it goes straight to finish and output. The block works on one
// item at a time; s_ready is high when it is idle. A finished result sits in
// an output register until taken; the next item can be accepted in the cycle
// after the result leaves the sequencer. Configuration writes go through
// cfg_we/cfg_index/cfg_data while idle; the user, not the block, ensures this.
module three_channel_rms_meter_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  trms_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output trms_pkg::out_item_t m_data
);
    import trms_pkg::*;

    dp_cmd_t   cmd;
    dp_sts_t   sts;
    out_item_t result;
    logic      busy, out_load, in_fire, out_free;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !busy;

    trms_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire, .out_free, .sts, .cmd, .busy, .out_load
    );

    trms_dp u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .in_item(s_data), .cmd, .sts, .result
    );

    // output register: hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_data_reg <= result;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("stall drop");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready) else $error("accept while busy");
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.rms_valid && m_data.empty_period)) else $error("flags");
`endif

endmodule
